>>> rtl/core/bda_pkg.sv
`default_nettype none
package bda_pkg;

    // default configuration
    localparam int DIGIT_COUNT_DEF = 11;
    localparam int VALUE_BITS_DEF  = 32;

    // fixed result field widths
    localparam int POS_W  = 4;
    localparam int CHAR_W = 6;

    // one BCD digit
    localparam int NIBBLE_W = 4;

    // binary bits folded into the BCD register per conversion cycle
    localparam int BITS_PER_STEP = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NUL  = 6'd0;

endpackage
`default_nettype wire

>>> rtl/core/binary_to_decimal_ascii.sv
// The double-dabble front converts each accepted value, a queue buffers the digits and the
// back end emits one character per cycle while m_ready stays high. The front can accept a
// new value while it hands the last one to the queue, so successive items overlap.
// Reset: synchronous, active-low aresetn clears the sequencer, queue and valids.
`default_nettype none
module binary_to_decimal_ascii #(
    parameter int DIGIT_COUNT = bda_pkg::DIGIT_COUNT_DEF,
    parameter int VALUE_BITS  = bda_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [VALUE_BITS-1:0]         s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bda_pkg::POS_W-1:0]          m_position,
    output logic [bda_pkg::CHAR_W-1:0]         m_char_code,
    output logic [bda_pkg::POS_W-1:0]          m_start_index,
    output logic                               m_last
);

    localparam int DIG_W = DIGIT_COUNT * bda_pkg::NIBBLE_W;
    localparam int IDX_W = $clog2(DIGIT_COUNT);
    localparam int Q_W   = DIG_W + IDX_W + 1;

    logic             f_valid, f_ready;
    logic [DIG_W-1:0] f_digits;
    logic [IDX_W-1:0] f_start;
    logic             f_zero;
    logic             b_valid, b_ready;
    logic [Q_W-1:0]   q_in, q_out;

    bda_front #(
        .DIGIT_COUNT(DIGIT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_value (s_value),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_digits(f_digits),
        .q_start (f_start),
        .q_zero  (f_zero)
    );

    assign q_in = {f_digits, f_start, f_zero};

    bda_queue #(
        .WIDTH(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  (q_in),
        .out_valid(b_valid),
        .out_ready(b_ready),
        .out_data (q_out)
    );

    bda_back #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_digits     (q_out[Q_W-1 -: DIG_W]),
        .q_start      (q_out[IDX_W:1]),
        .q_zero       (q_out[0]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_char_code  (m_char_code),
        .m_start_index(m_start_index),
        .m_last       (m_last)
    );

endmodule
`default_nettype wire

>>> rtl/core/bda_front.sv
`default_nettype none
module bda_front #(
    parameter int DIGIT_COUNT = bda_pkg::DIGIT_COUNT_DEF,
    parameter int VALUE_BITS  = bda_pkg::VALUE_BITS_DEF,
    localparam int DIG_W      = DIGIT_COUNT * bda_pkg::NIBBLE_W,
    localparam int IDX_W      = $clog2(DIGIT_COUNT)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VALUE_BITS-1:0] s_value,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output logic [DIG_W-1:0]           q_digits,
    output logic [IDX_W-1:0]           q_start,
    output logic                       q_zero
);

    localparam int STEPS = (VALUE_BITS + bda_pkg::BITS_PER_STEP - 1) / bda_pkg::BITS_PER_STEP;
    localparam int BIN_W = STEPS * bda_pkg::BITS_PER_STEP;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_DONE = 3'b100
    } front_state_t;

    front_state_t     state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [DIG_W-1:0] bcd_reg;
    logic [BIN_W-1:0] bin_step;
    logic [DIG_W-1:0] bcd_step;
    logic             accept;
    logic             push;

    assign push    = (state_reg == F_DONE) && q_ready;
    assign s_ready = (state_reg == F_IDLE) || push;
    assign accept  = s_valid && s_ready;
    assign q_valid = (state_reg == F_DONE);

    // double-dabble: BITS_PER_STEP shift-and-adjust steps per cycle
    always_comb begin
        bcd_step = bcd_reg;
        bin_step = bin_reg;
        for (int s = 0; s < bda_pkg::BITS_PER_STEP; s++) begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                if (bcd_step[d*bda_pkg::NIBBLE_W +: bda_pkg::NIBBLE_W] >= 4'd5) begin
                    bcd_step[d*bda_pkg::NIBBLE_W +: bda_pkg::NIBBLE_W] =
                        bcd_step[d*bda_pkg::NIBBLE_W +: bda_pkg::NIBBLE_W] + 4'd3;
                end
            end
            // top carry drops out, so the value is kept modulo 10^DIGIT_COUNT
            bcd_step = {bcd_step[DIG_W-2:0], bin_step[BIN_W-1]};
            bin_step = {bin_step[BIN_W-2:0], 1'b0};
        end
    end

    // first non-zero digit, position 0 is most significant
    always_comb begin
        q_start = '0;
        q_zero  = 1'b1;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            if (bcd_reg[(DIGIT_COUNT-1-i)*bda_pkg::NIBBLE_W +: bda_pkg::NIBBLE_W] != '0) begin
                q_start = IDX_W'(i);
                q_zero  = 1'b0;
            end
        end
    end
    assign q_digits = bcd_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) state_next = F_CONV;
            end
            F_CONV: begin
                if (cnt_reg == CNT_LAST) state_next = F_DONE;
            end
            F_DONE: begin
                if (accept)    state_next = F_CONV;
                else if (push) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                cnt_reg <= '0;
            end else if (state_reg == F_CONV) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            bin_reg <= BIN_W'(s_value);
            bcd_reg <= '0;
        end else if (state_reg == F_CONV) begin
            bin_reg <= bin_step;
            bcd_reg <= bcd_step;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/bda_queue.sv
`default_nettype none
module bda_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             wr_en;
    logic             rd_en;

    assign in_ready  = (count_reg != DEPTH);
    assign out_valid = (count_reg != 2'd0);
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en) rd_ptr_reg <= ~rd_ptr_reg;
            if (wr_en && !rd_en)      count_reg <= count_reg + 2'd1;
            else if (rd_en && !wr_en) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_ptr_reg] <= in_data;
    end

    // fill level never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= DEPTH)
        else $error("queue fill level above depth");

endmodule
`default_nettype wire

>>> rtl/core/bda_back.sv
`default_nettype none
module bda_back #(
    parameter int DIGIT_COUNT = bda_pkg::DIGIT_COUNT_DEF,
    localparam int DIG_W      = DIGIT_COUNT * bda_pkg::NIBBLE_W,
    localparam int IDX_W      = $clog2(DIGIT_COUNT)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire logic [DIG_W-1:0]              q_digits,
    input  wire logic [IDX_W-1:0]              q_start,
    input  wire logic                          q_zero,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bda_pkg::POS_W-1:0]          m_position,
    output logic [bda_pkg::CHAR_W-1:0]         m_char_code,
    output logic [bda_pkg::POS_W-1:0]          m_start_index,
    output logic                               m_last
);

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DIGIT_COUNT - 1);
    localparam logic [IDX_W-1:0] NUL_POS  = IDX_W'(1);
    localparam logic [bda_pkg::POS_W-1:0] LAST_POS_OUT = bda_pkg::POS_W'(DIGIT_COUNT - 1);

    logic [DIG_W-1:0]             digits_reg;
    logic [IDX_W-1:0]             start_reg;
    logic                         zero_reg;
    logic [IDX_W-1:0]             pos_reg;
    logic                         cur_valid_reg;
    logic                         m_valid_reg;
    logic [bda_pkg::POS_W-1:0]    m_position_reg;
    logic [bda_pkg::CHAR_W-1:0]   m_char_reg;
    logic [bda_pkg::POS_W-1:0]    m_start_reg;
    logic                         m_last_reg;
    logic                         out_load;
    logic                         cur_last;
    logic                         pop;
    logic [bda_pkg::CHAR_W-1:0]   char_next;

    assign out_load = cur_valid_reg && (!m_valid_reg || m_ready);
    assign cur_last = (pos_reg == LAST_POS);
    assign q_ready  = !cur_valid_reg || (out_load && cur_last);
    assign pop      = q_valid && q_ready;

    // current character: top digit of the shifting register, NUL after a lone zero
    always_comb begin
        if (zero_reg && pos_reg == NUL_POS) begin
            char_next = bda_pkg::ASCII_NUL;
        end else begin
            char_next = bda_pkg::ASCII_ZERO +
                bda_pkg::CHAR_W'(digits_reg[DIG_W-1 -: bda_pkg::NIBBLE_W]);
        end
    end

    // item being emitted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            pos_reg       <= '0;
        end else if (out_load) begin
            if (cur_last) begin
                cur_valid_reg <= 1'b0;
                pos_reg       <= '0;
            end else begin
                pos_reg <= pos_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            digits_reg <= q_digits;
            start_reg  <= q_start;
            zero_reg   <= q_zero;
        end else if (out_load) begin
            digits_reg <= {digits_reg[DIG_W-bda_pkg::NIBBLE_W-1:0], {bda_pkg::NIBBLE_W{1'b0}}};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_position_reg <= pos_reg[bda_pkg::POS_W-1:0];
            m_char_reg     <= char_next;
            m_start_reg    <= zero_reg ? '0 : start_reg[bda_pkg::POS_W-1:0];
            m_last_reg     <= cur_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_position    = m_position_reg;
    assign m_char_code   = m_char_reg;
    assign m_start_index = m_start_reg;
    assign m_last        = m_last_reg;

    // last flag only on the final position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_position_reg == LAST_POS_OUT))
        else $error("last flag on wrong position");

    // terminator only at position one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_char_reg == bda_pkg::ASCII_NUL) |-> (m_position_reg == 4'd1))
        else $error("terminator at unexpected position");

    // position counter rests at zero between items
    assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_valid_reg |-> (pos_reg == '0))
        else $error("position counter not cleared while idle");

endmodule
`default_nettype wire

>>> tb/sv/bda_text_checker.sv
`timescale 1ns / 1ps

// Watches both channels of binary_to_decimal_ascii, predicts the DIGIT_COUNT
// characters of every accepted value and compares them in order.
module bda_text_checker
    import bda_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [VALUE_BITS-1:0] s_value,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [POS_W-1:0]      m_position,
    input  wire logic [CHAR_W-1:0]     m_char_code,
    input  wire logic [POS_W-1:0]      m_start_index,
    input  wire logic                  m_last,
    output int                         error_count,
    output int                         pending_chars
);

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  start_index;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];
    int         char_seen = 0;

    initial begin
        error_count   = 0;
        pending_chars = 0;
    end

    // Split the value into decimal digits, MSD first, and queue one char per slot
    function automatic void queue_text_for_value(input logic [VALUE_BITS-1:0] value);
        logic [3:0]       digit [DIGIT_COUNT];
        logic [63:0]      rest;
        logic [POS_W-1:0] first_nonzero;
        bit               all_zero;
        text_char_t       c;
        rest          = 64'(value);
        first_nonzero = '0;
        all_zero      = 1'b1;
        for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
            digit[i] = 4'(rest % 64'd10);
            rest     = rest / 64'd10;
        end
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (all_zero && digit[i] != 4'd0) begin
                first_nonzero = POS_W'(i);
                all_zero      = 1'b0;
            end
        end
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            c.position    = POS_W'(i);
            c.char_code   = ASCII_ZERO + CHAR_W'(digit[i]);
            // zero value: a terminator follows the single '0'
            if (all_zero && i == 1)
                c.char_code = ASCII_NUL;
            c.start_index = first_nonzero;
            c.last        = (i == DIGIT_COUNT - 1);
            expected_text.push_back(c);
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on char %0d: %s got %0d, expected %0d",
                 $realtime, char_seen, field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            // result side: compare against the oldest expected char
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch("unexpected char, code", m_char_code, -1);
                end else begin
                    want = expected_text.pop_front();
                    if (m_position !== want.position)
                        report_mismatch("position", m_position, want.position);
                    if (m_char_code !== want.char_code)
                        report_mismatch("char_code", m_char_code, want.char_code);
                    if (m_start_index !== want.start_index)
                        report_mismatch("start_index", m_start_index, want.start_index);
                    if (m_last !== want.last)
                        report_mismatch("last", m_last, want.last);
                end
                char_seen++;
            end
            // input side: every accepted item yields a full line of text
            if (s_valid && s_ready)
                queue_text_for_value(s_value);
        end
        pending_chars <= expected_text.size();
    end

endmodule

>>> tb/sv/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
    import bda_pkg::*;

    localparam int DIGIT_COUNT  = DIGIT_COUNT_DEF;
    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int RANDOM_ITEMS = 310;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [31:0] DIRECTED [23] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
        32'd12345, 32'd1000, 32'd999999999, 32'd1000000000, 32'd1000000001,
        32'd2147483647, 32'd2147483648, 32'd3999999999, 32'd4000000000,
        32'd4294967294, 32'd4294967295, 32'h55555555, 32'hAAAAAAAA,
        32'd0, 32'd7
    };

    logic                   aclk    = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [VALUE_BITS-1:0]  s_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [POS_W-1:0]       m_position;
    logic [CHAR_W-1:0]      m_char_code;
    logic [POS_W-1:0]       m_start_index;
    logic                   m_last;

    int error_count;
    int pending_chars;
    int cycle_count = 0;
    bit no_idling   = 1'b0;

    binary_to_decimal_ascii #(
        .DIGIT_COUNT(DIGIT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_char_code  (m_char_code),
        .m_start_index(m_start_index),
        .m_last       (m_last)
    );

    bda_text_checker #(
        .DIGIT_COUNT(DIGIT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) text_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_position   (m_position),
        .m_char_code  (m_char_code),
        .m_start_index(m_start_index),
        .m_last       (m_last),
        .error_count  (error_count),
        .pending_chars(pending_chars)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver backpressure: m_ready is low with a chance of 15 in 100 unless no_idling is set
    always @(posedge aclk) begin
        if (no_idling)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 15);
    end

    // Random value mix: full range, tiny, a chosen digit count, round numbers
    function automatic logic [31:0] pick_value();
        logic [63:0] scale;
        int          k;
        scale = 64'd1;
        k     = $urandom_range(10, 1);
        for (int i = 0; i < k; i++)
            scale = scale * 64'd10;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(20);
            2: return 32'(64'($urandom) % scale);
            default: begin
                // digit times power of ten, optionally minus one
                scale = (scale / 64'd10) * 64'($urandom_range(9, 1));
                if ($urandom_range(1))
                    scale = scale - 64'd1;
                if (scale > 64'hFFFF_FFFF)
                    scale = 64'hFFFF_FFFF;
                return 32'(scale);
            end
        endcase
    endfunction

    // Offer one item; valid is only lowered for an idle gap
    task automatic send_value(input logic [31:0] value);
        while (!no_idling && $urandom_range(99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold off the sender until every char in flight has been checked
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_chars != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        foreach (DIRECTED[i])
            send_value(DIRECTED[i]);

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idling = (n >= 100 && n < 180);
            if (n == 240)
                wait_for_drain();
            send_value(pick_value());
        end
        no_idling = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bda_pkg.sv
rtl/core/bda_front.sv
rtl/core/bda_queue.sv
rtl/core/bda_back.sv
rtl/core/binary_to_decimal_ascii.sv
tb/sv/bda_text_checker.sv
tb/sv/tb_binary_to_decimal_ascii.sv
